[sv/vrt_pkg.sv]
package vrt_pkg;

  localparam int SIZE_X_DEF    = 32;
  localparam int SIZE_Y_DEF    = 32;
  localparam int SIZE_Z_DEF    = 32;
  localparam int MAX_STEPS_DEF = 100;

  // widest world is 1024 cubed
  localparam int ADDR_MAX_W  = 30;
  // start cell spans 17 bits, the walk adds at most a few thousand steps
  localparam int CELL_W      = 18;
  localparam int ID_W        = 6;
  // crossing times stay below max_dist plus one step time
  localparam int T_W         = 36;
  localparam int Q_W         = 33;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_RAY   = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [T_W-1:0] T_SAT = '1;

  typedef logic signed [CELL_W-1:0] cell_t;

  typedef struct packed {
    cell_t       start_cell;
    logic [16:0] gap;
    logic [31:0] mag;
    logic        pos;
    logic        zero;
  } axis_t;

  typedef struct packed {
    logic [1:0]            op;
    logic                  inw;
    logic [ADDR_MAX_W-1:0] addr;
    logic [ID_W-1:0]       id;
    axis_t [2:0]           ax;
    logic [30:0]           maxd;
  } item_t;

  function automatic logic in_world(cell_t x, cell_t y, cell_t z, int sx, int sy, int sz);
    return (x >= 0) && (x < sx) && (y >= 0) && (y < sy) && (z >= 0) && (z < sz);
  endfunction

  function automatic logic [ADDR_MAX_W-1:0] cell_addr(cell_t x, cell_t y, cell_t z,
                                                       int sx, int sy);
    logic [ADDR_MAX_W-1:0] ux;
    logic [ADDR_MAX_W-1:0] uy;
    logic [ADDR_MAX_W-1:0] uz;
    ux = ADDR_MAX_W'(x);
    uy = ADDR_MAX_W'(y);
    uz = ADDR_MAX_W'(z);
    return ux + ADDR_MAX_W'(sx) * (uy + ADDR_MAX_W'(sy) * uz);
  endfunction

endpackage

[sv/vrt_ram.sv]
module vrt_ram #(
  parameter int W     = 6,
  parameter int DEPTH = 32768
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                             wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/vrt_div.sv]
module vrt_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [vrt_pkg::Q_W-1:0] num,
  input  logic [31:0]          den,
  output logic                 done,
  output logic [vrt_pkg::Q_W-1:0] quo
);

  logic [5:0]              cnt;
  logic                    busy;
  logic [31:0]             rem;
  logic [31:0]             den_r;
  logic [vrt_pkg::Q_W-1:0] qn;
  logic [32:0]             trial;
  logic [32:0]             diff;
  logic                    ge;

  // restoring division, one quotient bit a cycle
  assign trial = {rem, qn[vrt_pkg::Q_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};
  assign quo   = qn;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 6'(vrt_pkg::Q_W - 1));
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        qn    <= num;
        den_r <= den;
      end else if (busy) begin
        rem <= ge ? diff[31:0] : trial[31:0];
        qn  <= {qn[vrt_pkg::Q_W-2:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(vrt_pkg::Q_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

[sv/vrt_front.sv]
module vrt_front #(
  parameter int SIZE_X = vrt_pkg::SIZE_X_DEF,
  parameter int SIZE_Y = vrt_pkg::SIZE_Y_DEF,
  parameter int SIZE_Z = vrt_pkg::SIZE_Z_DEF
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic signed [15:0] cell_x,
  input  logic signed [15:0] cell_y,
  input  logic signed [15:0] cell_z,
  input  logic [5:0]         block_id,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic [30:0]        max_dist,
  input  logic               q_full,
  input  logic               clearing,
  output logic               push,
  output vrt_pkg::item_t     item
);

  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];
  vrt_pkg::cell_t     cx, cy, cz;

  assign org[0] = origin_x;
  assign org[1] = origin_y;
  assign org[2] = origin_z;
  assign dir[0] = dir_x;
  assign dir[1] = dir_y;
  assign dir[2] = dir_z;

  assign cx = vrt_pkg::CELL_W'(cell_x);
  assign cy = vrt_pkg::CELL_W'(cell_y);
  assign cz = vrt_pkg::CELL_W'(cell_z);

  assign in_stall = q_full || clearing;
  assign push     = in_valid && !in_stall && (mode != vrt_pkg::OP_NONE);

  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic signed [37:0] prod;
    logic signed [37:0] nudge;
    logic signed [32:0] pos;
    logic               dpos;
    assign prod  = 38'(dir[k]) * 38'sd33;
    assign nudge = prod >>> 16;
    assign pos   = 33'(org[k]) + 33'(nudge);
    assign dpos  = !dir[k][31] && (dir[k] != 32'sd0);
    assign item.ax[k].start_cell = vrt_pkg::CELL_W'($signed(pos[32:16]));
    assign item.ax[k].gap  = dpos ? (17'h10000 - {1'b0, pos[15:0]}) : {1'b0, pos[15:0]};
    assign item.ax[k].mag  = dir[k][31] ? (~dir[k] + 32'd1) : dir[k];
    assign item.ax[k].pos  = dpos;
    assign item.ax[k].zero = (dir[k] == 32'sd0);
  end

  assign item.op   = mode;
  assign item.inw  = vrt_pkg::in_world(cx, cy, cz, SIZE_X, SIZE_Y, SIZE_Z);
  assign item.addr = vrt_pkg::cell_addr(cx, cy, cz, SIZE_X, SIZE_Y);
  assign item.id   = block_id;
  assign item.maxd = max_dist;

endmodule

[sv/vrt_queue.sv]
module vrt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  vrt_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output vrt_pkg::item_t head
);

  localparam int PW = vrt_pkg::QUEUE_DEPTH > 1 ? $clog2(vrt_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(vrt_pkg::QUEUE_DEPTH + 1);

  vrt_pkg::item_t entries [vrt_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  cnt;

  assign full  = cnt == CW'(vrt_pkg::QUEUE_DEPTH);
  assign valid = cnt != '0;
  assign head  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_item;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(vrt_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(vrt_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      cnt <= cnt + CW'(push) - CW'(pop);
    end
  end

endmodule

[sv/vrt_back.sv]
module vrt_back #(
  parameter int SIZE_X    = vrt_pkg::SIZE_X_DEF,
  parameter int SIZE_Y    = vrt_pkg::SIZE_Y_DEF,
  parameter int SIZE_Z    = vrt_pkg::SIZE_Z_DEF,
  parameter int MAX_STEPS = vrt_pkg::MAX_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  vrt_pkg::item_t     q_item,
  output logic               q_pop,
  output logic               clearing,
  input  logic               cfg_we,
  input  logic [63:0]        cfg_wdata,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic signed [15:0] hit_x,
  output logic signed [15:0] hit_y,
  output logic signed [15:0] hit_z,
  output logic signed [15:0] prev_x,
  output logic signed [15:0] prev_y,
  output logic signed [15:0] prev_z,
  output logic [5:0]         read_value
);

  localparam int CELLS  = SIZE_X * SIZE_Y * SIZE_Z;
  localparam int ADDR_W = CELLS > 1 ? $clog2(CELLS) : 1;
  localparam int STEP_W = $clog2(MAX_STEPS + 1);
  localparam int T_W    = vrt_pkg::T_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_EV    = 3'd4;
  localparam logic [2:0] S_RDV   = 3'd5;

  logic [2:0]              state;
  logic [ADDR_W-1:0]       clr_addr;
  logic [63:0]             solid_mask;
  vrt_pkg::cell_t          c [3];
  vrt_pkg::cell_t          p [3];
  logic [T_W-1:0]          tm [3];
  logic [T_W-1:0]          td [3];
  logic                    stp [3];
  logic                    zr [3];
  logic [30:0]             maxd;
  logic [STEP_W-1:0]       cnt;
  logic                    inw;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [5:0]              ram_wdata;
  logic [5:0]              ram_rdata;
  logic [ADDR_W-1:0]       cur_addr;
  logic                    cur_inw;
  logic                    div_start;
  logic [2:0]              div_done;
  logic [2:0]              tm_done;
  logic [vrt_pkg::Q_W-1:0] td_q [3];
  logic [vrt_pkg::Q_W-1:0] tm_q [3];
  logic [5:0]              cur_id;
  logic                    solid;
  logic [1:0]              sel;
  logic                    over;

  assign clearing  = state == S_CLEAR;
  assign q_pop     = (state == S_IDLE) && q_valid && !out_valid;
  assign div_start = q_pop && (q_item.op == vrt_pkg::OP_RAY);

  assign cur_addr = ADDR_W'(vrt_pkg::cell_addr(c[0], c[1], c[2], SIZE_X, SIZE_Y));
  assign cur_inw  = vrt_pkg::in_world(c[0], c[1], c[2], SIZE_X, SIZE_Y, SIZE_Z);

  assign ram_we    = clearing || (q_pop && (q_item.op == vrt_pkg::OP_WRITE) && q_item.inw);
  assign ram_waddr = clearing ? clr_addr : q_item.addr[ADDR_W-1:0];
  assign ram_wdata = clearing ? 6'd0 : q_item.id;
  assign ram_raddr = (state == S_RD) ? cur_addr : q_item.addr[ADDR_W-1:0];

  vrt_ram #(.W(6), .DEPTH(CELLS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  for (genvar k = 0; k < 3; k++) begin : g_div
    vrt_div u_td (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .num   (33'h1_0000_0000),
      .den   (q_item.ax[k].mag),
      .done  (div_done[k]),
      .quo   (td_q[k])
    );
    vrt_div u_tm (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .num   ({q_item.ax[k].gap, 16'h0}),
      .den   (q_item.ax[k].mag),
      .done  (tm_done[k]),
      .quo   (tm_q[k])
    );
  end

  assign cur_id = inw ? ram_rdata : 6'd0;
  assign solid  = (cur_id != 6'd0) && solid_mask[cur_id];

  // z wins every tie, y wins a tie with x
  always_comb begin
    if (tm[0] < tm[1]) begin
      sel = (tm[0] < tm[2]) ? 2'd0 : 2'd2;
    end else begin
      sel = (tm[1] < tm[2]) ? 2'd1 : 2'd2;
    end
  end
  assign over = tm[sel] > T_W'(maxd);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      solid_mask <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        solid_mask <= cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == ADDR_W'(CELLS - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            unique case (q_item.op)
              vrt_pkg::OP_READ: begin
                inw   <= q_item.inw;
                state <= S_RDV;
              end
              vrt_pkg::OP_RAY: begin
                for (int k = 0; k < 3; k++) begin
                  c[k]   <= q_item.ax[k].start_cell;
                  stp[k] <= q_item.ax[k].pos;
                  zr[k]  <= q_item.ax[k].zero;
                end
                maxd  <= q_item.maxd;
                state <= S_DIV;
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          if ((&div_done) && (&tm_done)) begin
            for (int k = 0; k < 3; k++) begin
              td[k] <= zr[k] ? vrt_pkg::T_SAT : T_W'(td_q[k]);
              tm[k] <= zr[k] ? vrt_pkg::T_SAT : T_W'(tm_q[k]);
              p[k]  <= c[k];
            end
            cnt   <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          inw   <= cur_inw;
          state <= S_EV;
        end
        S_EV: begin
          if (solid) begin
            out_valid  <= 1'b1;
            hit        <= 1'b1;
            hit_x      <= c[0][15:0];
            hit_y      <= c[1][15:0];
            hit_z      <= c[2][15:0];
            prev_x     <= p[0][15:0];
            prev_y     <= p[1][15:0];
            prev_z     <= p[2][15:0];
            read_value <= 6'd0;
            state      <= S_IDLE;
          end else begin
            for (int k = 0; k < 3; k++) begin
              p[k] <= c[k];
            end
            if (over || (cnt == STEP_W'(MAX_STEPS - 1))) begin
              out_valid  <= 1'b1;
              hit        <= 1'b0;
              hit_x      <= '0;
              hit_y      <= '0;
              hit_z      <= '0;
              prev_x     <= c[0][15:0];
              prev_y     <= c[1][15:0];
              prev_z     <= c[2][15:0];
              read_value <= 6'd0;
              state      <= S_IDLE;
            end else begin
              state <= S_RD;
            end
            if (!over) begin
              for (int k = 0; k < 3; k++) begin
                if (sel == 2'(k)) begin
                  c[k]  <= stp[k] ? c[k] + vrt_pkg::CELL_W'(1) : c[k] - vrt_pkg::CELL_W'(1);
                  tm[k] <= tm[k] + td[k];
                end
              end
              cnt <= cnt + STEP_W'(1);
            end
          end
        end
        S_RDV: begin
          out_valid  <= 1'b1;
          hit        <= 1'b0;
          hit_x      <= '0;
          hit_y      <= '0;
          hit_z      <= '0;
          prev_x     <= '0;
          prev_y     <= '0;
          prev_z     <= '0;
          read_value <= cur_id;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/voxel_ray_traversal_unit.sv]
// voxel store with a grid ray walk. after reset the store is swept to air, one
// cell a cycle, all SIZE_X*SIZE_Y*SIZE_Z cells (32768 by default); in_stall
// stays high meanwhile, solid_mask writes are taken as ever. a write word
// gives no result, a read word costs one registered read of the voxel
// memory, a ray word a setup (three pairs of bit-serial divisions, a
// reciprocal and a boundary distance per axis, run side by side) and then a
// walk of at most MAX_STEPS cells, each one registered read of the memory.
// one word is worked at a time; a two-entry queue lets the front take new
// words while a ray walks, and the result register holds until taken.
module voxel_ray_traversal_unit #(
  parameter int SIZE_X    = vrt_pkg::SIZE_X_DEF,
  parameter int SIZE_Y    = vrt_pkg::SIZE_Y_DEF,
  parameter int SIZE_Z    = vrt_pkg::SIZE_Z_DEF,
  parameter int MAX_STEPS = vrt_pkg::MAX_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration, solid_mask only
  input  logic               cfg_we,
  input  logic [63:0]        cfg_wdata,
  // input words
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic signed [15:0] cell_x,
  input  logic signed [15:0] cell_y,
  input  logic signed [15:0] cell_z,
  input  logic [5:0]         block_id,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic [30:0]        max_dist,
  // result words
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic signed [15:0] hit_x,
  output logic signed [15:0] hit_y,
  output logic signed [15:0] hit_z,
  output logic signed [15:0] prev_x,
  output logic signed [15:0] prev_y,
  output logic signed [15:0] prev_z,
  output logic [5:0]         read_value
);

  logic           push;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  logic           clearing;
  vrt_pkg::item_t push_item;
  vrt_pkg::item_t q_item;

  // front: decode, bounds check, cell address, ray nudge and boundary distance
  vrt_front #(.SIZE_X(SIZE_X), .SIZE_Y(SIZE_Y), .SIZE_Z(SIZE_Z)) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .cell_x   (cell_x),
    .cell_y   (cell_y),
    .cell_z   (cell_z),
    .block_id (block_id),
    .origin_x (origin_x),
    .origin_y (origin_y),
    .origin_z (origin_z),
    .dir_x    (dir_x),
    .dir_y    (dir_y),
    .dir_z    (dir_z),
    .max_dist (max_dist),
    .q_full   (q_full),
    .clearing (clearing),
    .push     (push),
    .item     (push_item)
  );

  vrt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_item)
  );

  // back: memory access, divisions, cell walk, result register
  vrt_back #(
    .SIZE_X    (SIZE_X),
    .SIZE_Y    (SIZE_Y),
    .SIZE_Z    (SIZE_Z),
    .MAX_STEPS (MAX_STEPS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .hit_x      (hit_x),
    .hit_y      (hit_y),
    .hit_z      (hit_z),
    .prev_x     (prev_x),
    .prev_y     (prev_y),
    .prev_z     (prev_z),
    .read_value (read_value)
  );

endmodule
